// ----- src/hmts_pkg.sv -----
// ============================================================================
// Height map triangle sampler package
// Shared widths, register codes, reset values and the word types that pass
// between the stages of the sampler.
// ============================================================================
package hmts_pkg;

    localparam int COORD_W    = 32;
    localparam int SAMPLE_W   = 16;
    localparam int STORE_AW   = 16;
    localparam int STORE_DEPTH = 1 << STORE_AW;
    localparam int FRAC_W     = 16;
    localparam int WEIGHT_W   = FRAC_W + 1;
    localparam int CPU_W      = 24;
    localparam int GAIN_W     = 16;
    localparam int GAIN_FRAC  = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [WEIGHT_W-1:0] ONE_Q16 = WEIGHT_W'(1 << FRAC_W);

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORIGIN_X       = 3'd0,
        CFG_ORIGIN_Y       = 3'd1,
        CFG_ORIGIN_Z       = 3'd2,
        CFG_CELLS_PER_UNIT = 3'd3,
        CFG_HEIGHT_GAIN    = 3'd4
    } cfg_index_t;

    localparam logic [CPU_W-1:0]  CPU_RESET  = 24'd65536;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd256;

    typedef struct packed {
        logic                      cmd;
        logic [STORE_AW-1:0]       sample_index;
        logic [SAMPLE_W-1:0]       sample_value;
        logic signed [COORD_W-1:0] query_x;
        logic signed [COORD_W-1:0] query_z;
    } hmts_in_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] height;
        logic                      in_range;
    } hmts_out_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] origin_x;
        logic signed [COORD_W-1:0] origin_y;
        logic signed [COORD_W-1:0] origin_z;
        logic [CPU_W-1:0]          cells_per_unit;
        logic [GAIN_W-1:0]         height_gain;
    } hmts_cfg_t;

    typedef struct packed {
        logic                is_query;
        logic [STORE_AW-1:0] sample_index;
        logic [SAMPLE_W-1:0] sample_value;
        logic                in_range;
        logic                upper;
        logic [STORE_AW-1:0] addr00;
        logic [STORE_AW-1:0] addr10;
        logic [STORE_AW-1:0] addr01;
        logic [STORE_AW-1:0] addr11;
        logic [WEIGHT_W-1:0] w0;
        logic [WEIGHT_W-1:0] w1;
        logic [WEIGHT_W-1:0] w2;
    } hmts_lookup_t;

    typedef struct packed {
        logic                in_range;
        logic                upper;
        logic [WEIGHT_W-1:0] w0;
        logic [WEIGHT_W-1:0] w1;
        logic [WEIGHT_W-1:0] w2;
        logic [SAMPLE_W-1:0] s00;
        logic [SAMPLE_W-1:0] s10;
        logic [SAMPLE_W-1:0] s01;
        logic [SAMPLE_W-1:0] s11;
    } hmts_blend_t;

endpackage

// ----- src/hmts_cell_map.sv -----
// ============================================================================
// Cell mapper
// Three pipeline stages: origin offset, scaling by cells per unit, then the
// range check, corner addresses and barycentric weights of the cell.
// ============================================================================
module hmts_cell_map import hmts_pkg::*; #(
    parameter int MAP_SIZE = 256
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  hmts_cfg_t    cfg,
    input  logic         in_valid,
    output logic         in_ready,
    input  hmts_in_t     in_data,
    output logic         out_valid,
    input  logic         out_ready,
    output hmts_lookup_t out_data
);

    localparam int CW      = $clog2(MAP_SIZE);
    localparam int LOFS_W  = COORD_W + 1;
    localparam int PROD_W  = LOFS_W + CPU_W + 1;
    localparam int CELL_W  = PROD_W - 2 * FRAC_W;
    localparam logic [CELL_W-1:0]   LAST_CELL = CELL_W'(MAP_SIZE - 1);
    localparam logic [STORE_AW-1:0] ROW_STEP  = STORE_AW'(MAP_SIZE);

    logic v1_reg, v2_reg, v3_reg;
    logic rdy1, rdy2, rdy3;

    logic                 q1_reg, q2_reg;
    logic [STORE_AW-1:0]  idx1_reg, idx2_reg;
    logic [SAMPLE_W-1:0]  val1_reg, val2_reg;
    logic [LOFS_W-1:0]    lx1_reg, lz1_reg, lx1_next, lz1_next;
    logic signed [PROD_W-1:0] ux2_reg, uz2_reg, ux2_next, uz2_next;
    hmts_lookup_t         lk3_reg, lk3_next;

    logic [FRAC_W-1:0]   fx, fz;
    logic [WEIGHT_W-1:0] fsum;
    logic [CW-1:0]       cx, cz;
    logic [STORE_AW-1:0] a00, a01;

    assign rdy3     = !v3_reg || out_ready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    always_comb begin
        lx1_next = {in_data.query_x[COORD_W-1], in_data.query_x}
                 - {cfg.origin_x[COORD_W-1], cfg.origin_x};
        lz1_next = {in_data.query_z[COORD_W-1], in_data.query_z}
                 - {cfg.origin_z[COORD_W-1], cfg.origin_z};
        ux2_next = $signed(lx1_reg) * $signed({1'b0, cfg.cells_per_unit});
        uz2_next = $signed(lz1_reg) * $signed({1'b0, cfg.cells_per_unit});
    end

    always_comb begin
        fx   = ux2_reg[2*FRAC_W-1:FRAC_W];
        fz   = uz2_reg[2*FRAC_W-1:FRAC_W];
        fsum = {1'b0, fx} + {1'b0, fz};
        cx   = ux2_reg[2*FRAC_W +: CW];
        cz   = uz2_reg[2*FRAC_W +: CW];
        a00  = STORE_AW'(cx) + STORE_AW'(cz) * ROW_STEP;
        a01  = a00 + ROW_STEP;

        lk3_next.is_query     = q2_reg;
        lk3_next.sample_index = idx2_reg;
        lk3_next.sample_value = val2_reg;
        lk3_next.in_range     = !ux2_reg[PROD_W-1] && !uz2_reg[PROD_W-1]
                              && (ux2_reg[PROD_W-1:2*FRAC_W] < LAST_CELL)
                              && (uz2_reg[PROD_W-1:2*FRAC_W] < LAST_CELL);
        lk3_next.upper        = fsum > ONE_Q16;
        lk3_next.addr00       = a00;
        lk3_next.addr10       = a00 + STORE_AW'(1);
        lk3_next.addr01       = a01;
        lk3_next.addr11       = a01 + STORE_AW'(1);
        if (fsum > ONE_Q16) begin
            lk3_next.w0 = ONE_Q16 - {1'b0, fz};
            lk3_next.w1 = fsum - ONE_Q16;
            lk3_next.w2 = ONE_Q16 - {1'b0, fx};
        end else begin
            lk3_next.w0 = ONE_Q16 - fsum;
            lk3_next.w1 = {1'b0, fx};
            lk3_next.w2 = {1'b0, fz};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                v1_reg <= in_valid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
            if (rdy3) begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            q1_reg   <= (in_data.cmd == CMD_QUERY);
            idx1_reg <= in_data.sample_index;
            val1_reg <= in_data.sample_value;
            lx1_reg  <= lx1_next;
            lz1_reg  <= lz1_next;
        end
        if (rdy2) begin
            q2_reg   <= q1_reg;
            idx2_reg <= idx1_reg;
            val2_reg <= val1_reg;
            ux2_reg  <= ux2_next;
            uz2_reg  <= uz2_next;
        end
        if (rdy3) begin
            lk3_reg <= lk3_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_data  = lk3_reg;

    a_weights_sum_to_one: assert property (@(posedge aclk) disable iff (!aresetn)
        v3_reg && lk3_reg.is_query && lk3_reg.in_range |->
        (19'(lk3_reg.w0) + 19'(lk3_reg.w1) + 19'(lk3_reg.w2)) == 19'(ONE_Q16))
        else $error("Barycentric weights do not sum to one.");

    a_stall_holds_word: assert property (@(posedge aclk) disable iff (!aresetn)
        v3_reg && !out_ready |=> v3_reg && $stable(lk3_reg))
        else $error("Stalled lookup word was lost or changed.");

    a_full_when_not_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_ready |-> v1_reg && v2_reg && v3_reg)
        else $error("Input stalled while the mapper has a free stage.");

endmodule

// ----- src/hmts_store.sv -----
// ============================================================================
// Height store
// Two copies of the sample map, each written by every load and read at two
// addresses, so all four cell corners come out in one registered read.
// ============================================================================
module hmts_store import hmts_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         in_valid,
    output logic         in_ready,
    input  hmts_lookup_t in_data,
    output logic         out_valid,
    input  logic         out_ready,
    output hmts_blend_t  out_data
);

    logic [SAMPLE_W-1:0] bank_a_mem [STORE_DEPTH];
    logic [SAMPLE_W-1:0] bank_b_mem [STORE_DEPTH];

    logic                v_reg;
    logic                in_range_reg, upper_reg;
    logic [WEIGHT_W-1:0] w0_reg, w1_reg, w2_reg;
    logic [SAMPLE_W-1:0] s00_reg, s10_reg, s01_reg, s11_reg;
    logic                wr_en;

    assign in_ready = !v_reg || out_ready;
    assign wr_en    = in_valid && in_ready && !in_data.is_query;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            bank_a_mem[in_data.sample_index] <= in_data.sample_value;
            bank_b_mem[in_data.sample_index] <= in_data.sample_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            s00_reg      <= bank_a_mem[in_data.addr00];
            s10_reg      <= bank_a_mem[in_data.addr10];
            s01_reg      <= bank_b_mem[in_data.addr01];
            s11_reg      <= bank_b_mem[in_data.addr11];
            in_range_reg <= in_data.in_range;
            upper_reg    <= in_data.upper;
            w0_reg       <= in_data.w0;
            w1_reg       <= in_data.w1;
            w2_reg       <= in_data.w2;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (in_ready) begin
            v_reg <= in_valid && in_data.is_query;
        end
    end

    assign out_valid         = v_reg;
    assign out_data.in_range = in_range_reg;
    assign out_data.upper    = upper_reg;
    assign out_data.w0       = w0_reg;
    assign out_data.w1       = w1_reg;
    assign out_data.w2       = w2_reg;
    assign out_data.s00      = s00_reg;
    assign out_data.s10      = s10_reg;
    assign out_data.s01      = s01_reg;
    assign out_data.s11      = s11_reg;

    a_load_gives_no_word: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |=> !v_reg)
        else $error("A load produced a result word.");

endmodule

// ----- src/hmts_blend.sv -----
// ============================================================================
// Triangle blend
// Four pipeline stages: weighted corner products, their sum, the height gain,
// then the origin offset with saturation into the output register.
// ============================================================================
module hmts_blend import hmts_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  hmts_cfg_t   cfg,
    input  logic        in_valid,
    output logic        in_ready,
    input  hmts_blend_t in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output hmts_out_t   out_data
);

    localparam int MUL_W  = WEIGHT_W + SAMPLE_W;
    localparam int ACC_W  = SAMPLE_W + FRAC_W;
    localparam int GPROD_W = ACC_W + GAIN_W;
    localparam int SCALED_W = GPROD_W - GAIN_FRAC;
    localparam int SUM_W  = SCALED_W + 2;
    localparam logic signed [SUM_W-1:0] POS_LIMIT = SUM_W'(64'sh7FFF_FFFF);
    localparam logic signed [SUM_W-1:0] NEG_LIMIT = -SUM_W'(64'sh8000_0000);

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;

    logic                in1_reg, in2_reg, in3_reg;
    logic [MUL_W-1:0]    p0_reg, p1_reg, p2_reg;
    logic [MUL_W-1:0]    p0_next, p1_next, p2_next;
    logic [ACC_W-1:0]    acc2_reg, acc2_next;
    logic [SCALED_W-1:0] sc3_reg, sc3_next;
    logic [GPROD_W-1:0]  gprod;
    logic signed [SUM_W-1:0] hsum;
    hmts_out_t           out4_reg, out4_next;

    logic [SAMPLE_W-1:0] sa, sb;

    assign rdy4     = !v4_reg || out_ready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    always_comb begin
        sa = in_data.upper ? in_data.s10 : in_data.s00;
        sb = in_data.upper ? in_data.s11 : in_data.s10;
        p0_next = MUL_W'(in_data.w0) * MUL_W'(sa);
        p1_next = MUL_W'(in_data.w1) * MUL_W'(sb);
        p2_next = MUL_W'(in_data.w2) * MUL_W'(in_data.s01);

        acc2_next = ACC_W'(p0_reg + p1_reg + p2_reg);

        gprod    = GPROD_W'(acc2_reg) * GPROD_W'(cfg.height_gain);
        sc3_next = gprod[GPROD_W-1:GAIN_FRAC];

        hsum = $signed({2'b00, sc3_reg})
             + $signed({{(SUM_W - COORD_W){cfg.origin_y[COORD_W-1]}}, cfg.origin_y});
        out4_next.in_range = in3_reg;
        if (!in3_reg) begin
            out4_next.height = '0;
        end else if (hsum > POS_LIMIT) begin
            out4_next.height = COORD_W'(POS_LIMIT);
        end else if (hsum < NEG_LIMIT) begin
            out4_next.height = COORD_W'(NEG_LIMIT);
        end else begin
            out4_next.height = hsum[COORD_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                v1_reg <= in_valid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
            if (rdy3) begin
                v3_reg <= v2_reg;
            end
            if (rdy4) begin
                v4_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            in1_reg <= in_data.in_range;
            p0_reg  <= p0_next;
            p1_reg  <= p1_next;
            p2_reg  <= p2_next;
        end
        if (rdy2) begin
            in2_reg  <= in1_reg;
            acc2_reg <= acc2_next;
        end
        if (rdy3) begin
            in3_reg <= in2_reg;
            sc3_reg <= sc3_next;
        end
        if (rdy4) begin
            out4_reg <= out4_next;
        end
    end

    assign out_valid = v4_reg;
    assign out_data  = out4_reg;

endmodule

// ----- src/heightmap_triangle_height_sampler_top.sv -----
// ============================================================================
// Height map triangle sampler
// Holds the configuration registers and chains the cell mapper, the height
// store and the triangle blend into one valid/ready pipeline.
// ============================================================================
// The block takes one input word per clock cycle while the output is not
// stalled, loads and queries mixed in any order. A query's result word passes
// eight register stages: three in the cell mapper, one registered read of the
// store and four in the blend. A load writes the store in the read stage, so
// any query accepted after it sees the new sample. The store is kept as two
// copies of 65536 samples each so that all four corners of a cell are read in
// the same cycle; no clearing pass is run after reset, and samples read
// before they are loaded are undefined. Configuration is written through the
// plain write port; the user must write it only while the pipeline is empty,
// which the block itself does not enforce.
module heightmap_triangle_height_sampler_top import hmts_pkg::*; #(
    parameter int MAP_SIZE = 256
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  hmts_in_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output hmts_out_t             m_data
);

    hmts_cfg_t    cfg_reg, cfg_next;
    logic         lk_valid, lk_ready;
    hmts_lookup_t lk_data;
    logic         bl_valid, bl_ready;
    hmts_blend_t  bl_data;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_ORIGIN_X:       cfg_next.origin_x       = cfg_wdata;
                CFG_ORIGIN_Y:       cfg_next.origin_y       = cfg_wdata;
                CFG_ORIGIN_Z:       cfg_next.origin_z       = cfg_wdata;
                CFG_CELLS_PER_UNIT: cfg_next.cells_per_unit = cfg_wdata[CPU_W-1:0];
                CFG_HEIGHT_GAIN:    cfg_next.height_gain    = cfg_wdata[GAIN_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.origin_x       <= '0;
            cfg_reg.origin_y       <= '0;
            cfg_reg.origin_z       <= '0;
            cfg_reg.cells_per_unit <= CPU_RESET;
            cfg_reg.height_gain    <= GAIN_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    hmts_cell_map #(
        .MAP_SIZE (MAP_SIZE)
    ) u_cell_map (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_data),
        .out_valid (lk_valid),
        .out_ready (lk_ready),
        .out_data  (lk_data)
    );

    hmts_store u_store (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (lk_valid),
        .in_ready  (lk_ready),
        .in_data   (lk_data),
        .out_valid (bl_valid),
        .out_ready (bl_ready),
        .out_data  (bl_data)
    );

    hmts_blend u_blend (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (bl_valid),
        .in_ready  (bl_ready),
        .in_data   (bl_data),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_data)
    );

endmodule

// ----- verif/hmts_height_checker.sv -----
`timescale 1ns / 100ps
// ============================================================================
// Height map sampler result checker
// Follows the register port and both word channels and keeps a copy of the
// sample store and the registers. From these it works out the height of each
// accepted query. Each result word is compared with the oldest open
// prediction, and the mismatch count goes back to the testbench top.
// ============================================================================
module hmts_height_checker import hmts_pkg::*; #(
    parameter int MAP_SIZE = 256
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  hmts_in_t              s_data,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  hmts_out_t             m_data,
    output int                    fail_count,
    output int                    pending,
    output int                    in_range_count
);

    hmts_cfg_t           regs;
    logic [SAMPLE_W-1:0] heights [STORE_DEPTH];
    hmts_out_t           expected_heights [$];
    int                  mismatches;
    int                  results_seen;
    int                  hits;

    task automatic report_mismatch(input string msg);
        mismatches++;
        // Only the first hundred are printed so that a broken build stays readable.
        if (mismatches <= 100) begin
            $display("[%0t] MISMATCH result %0d: %s", $time, results_seen, msg);
        end
    endtask

    function automatic longint corner_sample(input longint x, input longint z);
        return longint'(heights[STORE_AW'(x + MAP_SIZE * z)]);
    endfunction

    function automatic hmts_out_t predict_height(input hmts_in_t w);
        longint    ux, uz, ix, iz, fx, fz, acc, h, unit;
        hmts_out_t r;
        unit = longint'(ONE_Q16);
        r = '0;
        ux = (longint'($signed(w.query_x)) - longint'($signed(regs.origin_x)))
            * longint'(regs.cells_per_unit);
        uz = (longint'($signed(w.query_z)) - longint'($signed(regs.origin_z)))
            * longint'(regs.cells_per_unit);
        if (ux < 0 || uz < 0) begin
            return r;
        end
        ix = ux >>> 32;
        iz = uz >>> 32;
        if (ix >= MAP_SIZE - 1 || iz >= MAP_SIZE - 1) begin
            return r;
        end
        fx = (ux >>> 16) & 64'hFFFF;
        fz = (uz >>> 16) & 64'hFFFF;
        if (fx + fz <= unit) begin
            acc = corner_sample(ix, iz) * (unit - fx - fz)
                + corner_sample(ix + 1, iz) * fx
                + corner_sample(ix, iz + 1) * fz;
        end else begin
            acc = corner_sample(ix + 1, iz) * (unit - fz)
                + corner_sample(ix + 1, iz + 1) * (fx + fz - unit)
                + corner_sample(ix, iz + 1) * (unit - fx);
        end
        h = ((acc * longint'(regs.height_gain)) >>> GAIN_FRAC)
            + longint'($signed(regs.origin_y));
        if (h > 64'sd2147483647) begin
            h = 64'sd2147483647;
        end
        if (h < -64'sd2147483648) begin
            h = -64'sd2147483648;
        end
        r.height   = h[COORD_W-1:0];
        r.in_range = 1'b1;
        return r;
    endfunction

    always @(posedge aclk) begin
        hmts_out_t want;
        if (!aresetn) begin
            regs.origin_x       = '0;
            regs.origin_y       = '0;
            regs.origin_z       = '0;
            regs.cells_per_unit = CPU_RESET;
            regs.height_gain    = GAIN_RESET;
            expected_heights.delete();
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (expected_heights.size() == 0) begin
                    report_mismatch($sformatf("unexpected word, height %0d in_range %0b",
                        m_data.height, m_data.in_range));
                end else begin
                    want = expected_heights.pop_front();
                    if (m_data.in_range !== want.in_range) begin
                        report_mismatch($sformatf("in_range %b, expected %b",
                            m_data.in_range, want.in_range));
                    end
                    if (m_data.height !== want.height) begin
                        report_mismatch($sformatf("height %0d (%h), expected %0d (%h)",
                            m_data.height, m_data.height, want.height, want.height));
                    end
                    if (want.in_range) begin
                        hits++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                if (s_data.cmd == CMD_LOAD) begin
                    heights[s_data.sample_index] = s_data.sample_value;
                end else begin
                    expected_heights.push_back(predict_height(s_data));
                end
            end
            if (cfg_wr_en) begin
                case (cfg_index_t'(cfg_index))
                    CFG_ORIGIN_X:       regs.origin_x       = cfg_wdata;
                    CFG_ORIGIN_Y:       regs.origin_y       = cfg_wdata;
                    CFG_ORIGIN_Z:       regs.origin_z       = cfg_wdata;
                    CFG_CELLS_PER_UNIT: regs.cells_per_unit = cfg_wdata[CPU_W-1:0];
                    CFG_HEIGHT_GAIN:    regs.height_gain    = cfg_wdata[GAIN_W-1:0];
                    default: ;
                endcase
            end
        end
        fail_count     <= mismatches;
        pending        <= expected_heights.size();
        in_range_count <= hits;
    end

endmodule

// ----- verif/heightmap_triangle_height_sampler_top_tb.sv -----
`timescale 1ns / 100ps
// ============================================================================
// Height map triangle sampler testbench
// Drives loads and queries with random gaps and output stalls through five
// register settings. The settings include the default scale, a saturating
// gain, zero scale and extreme origins. Before each query the testbench loads
// every sample that the query reads. A directed opening set covers corners,
// the triangle split, the map edges and negative offsets. The checker
// predicts and compares every result word.
// ============================================================================
module heightmap_triangle_height_sampler_top_tb;
    import hmts_pkg::*;

    localparam int MAP_SIZE          = 256;
    localparam int NUM_SETTINGS      = 5;
    localparam int ITEMS_PER_SETTING = 120;
    localparam int DRAIN_CYCLES      = 12;
    localparam int HOLD_CYCLES       = 250;
    localparam int IDLE_LIMIT        = 5000;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    hmts_in_t              s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    hmts_out_t             m_data;

    int        fail_count;
    int        pending;
    int        in_range_count;
    hmts_cfg_t active_cfg;
    bit        loaded [STORE_DEPTH];
    int        loads_sent;
    int        queries_sent;
    int        steady_left;

    heightmap_triangle_height_sampler_top #(
        .MAP_SIZE (MAP_SIZE)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    hmts_height_checker #(
        .MAP_SIZE (MAP_SIZE)
    ) u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data         (s_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data         (m_data),
        .fail_count     (fail_count),
        .pending        (pending),
        .in_range_count (in_range_count)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    task automatic apply_config(input hmts_cfg_t c);
        active_cfg = c;
        for (int i = CFG_ORIGIN_X; i <= CFG_HEIGHT_GAIN; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            case (cfg_index_t'(i))
                CFG_ORIGIN_X:       cfg_wdata <= c.origin_x;
                CFG_ORIGIN_Y:       cfg_wdata <= c.origin_y;
                CFG_ORIGIN_Z:       cfg_wdata <= c.origin_z;
                CFG_CELLS_PER_UNIT: cfg_wdata <= CFG_DATA_W'(c.cells_per_unit);
                CFG_HEIGHT_GAIN:    cfg_wdata <= CFG_DATA_W'(c.height_gain);
                default: ;
            endcase
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
    endtask

    task automatic push_word(input hmts_in_t w);
        int gap;
        if (steady_left > 0) begin
            steady_left--;
            gap = 0;
        end else begin
            gap = $urandom_range(0, 10);
            if ($urandom_range(0, 15) == 0) begin
                steady_left = $urandom_range(10, 40);
            end
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_load(input logic [STORE_AW-1:0] idx, input logic [SAMPLE_W-1:0] val);
        hmts_in_t w;
        w.cmd          = CMD_LOAD;
        w.sample_index = idx;
        w.sample_value = val;
        w.query_x      = $urandom;
        w.query_z      = $urandom;
        push_word(w);
        loaded[idx] = 1'b1;
        loads_sent++;
    endtask

    function automatic bit map_cell(input logic signed [COORD_W-1:0] q,
                                    input logic signed [COORD_W-1:0] org, output int cell_no);
        longint u;
        u = (longint'(q) - longint'(org)) * longint'(active_cfg.cells_per_unit);
        cell_no = int'(u >>> 32);
        return u >= 0 && (u >>> 32) < MAP_SIZE - 1;
    endfunction

    task automatic send_query(input logic signed [COORD_W-1:0] qx,
                              input logic signed [COORD_W-1:0] qz);
        int                  cx;
        int                  cz;
        logic [STORE_AW-1:0] idx;
        hmts_in_t            w;
        if (map_cell(qx, active_cfg.origin_x, cx) && map_cell(qz, active_cfg.origin_z, cz)) begin
            for (int dz = 0; dz < 2; dz++) begin
                for (int dx = 0; dx < 2; dx++) begin
                    idx = STORE_AW'(cx + dx + MAP_SIZE * (cz + dz));
                    if (!loaded[idx]) begin
                        send_load(idx, SAMPLE_W'($urandom));
                    end
                end
            end
        end
        w.cmd          = CMD_QUERY;
        w.sample_index = STORE_AW'($urandom);
        w.sample_value = SAMPLE_W'($urandom);
        w.query_x      = qx;
        w.query_z      = qz;
        push_word(w);
        queries_sent++;
    endtask

    function automatic logic signed [COORD_W-1:0] pick_coord(
            input logic signed [COORD_W-1:0] org);
        longint cell_no;
        longint u;
        longint q;
        int     pick;
        pick = $urandom_range(0, 9);
        if (pick < 4) begin
            cell_no = longint'($urandom_range(0, 7));
        end else if (pick < 8) begin
            cell_no = longint'(MAP_SIZE - 2) - longint'($urandom_range(0, 7));
        end else begin
            cell_no = longint'($urandom_range(0, MAP_SIZE - 2));
        end
        case ($urandom_range(0, 5))
            0:       u = cell_no << 32;
            1:       u = (cell_no << 32) | 64'hFFFF_FFFF;
            default: u = (cell_no << 32) | longint'($urandom);
        endcase
        if (active_cfg.cells_per_unit == 0) begin
            return $urandom;
        end
        q = longint'(org) + u / longint'(active_cfg.cells_per_unit)
            + longint'($urandom_range(0, 1));
        if (q > 64'sd2147483647) begin
            q = 64'sd2147483647;
        end
        if (q < -64'sd2147483648) begin
            q = -64'sd2147483648;
        end
        return q[COORD_W-1:0];
    endfunction

    initial begin
        int gap;
        int taken;
        int calm_left;
        taken     = 0;
        calm_left = 0;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (taken == 40 || taken == 200) begin
                gap = HOLD_CYCLES;
            end else if (calm_left > 0) begin
                calm_left--;
                gap = 0;
            end else begin
                gap = $urandom_range(0, 10);
                if ($urandom_range(0, 15) == 0) begin
                    calm_left = $urandom_range(10, 40);
                end
            end
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            taken++;
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("Timed out after %0d cycles with no word moving.", IDLE_LIMIT);
        $display("heightmap_triangle_height_sampler_top regression: fail");
        $finish;
    end

    initial begin
        hmts_cfg_t settings [NUM_SETTINGS];
        int        stop_at;
        int        pick;
        settings[0] = '{32'sd0, 32'sd0, 32'sd0, CPU_RESET, GAIN_RESET};
        settings[1] = '{32'shFFFA_8000, 32'sh7FFF_0000, 32'sh0003_0000, 24'h02_0000, 16'hFFFF};
        settings[2] = '{32'($urandom), 32'sh8000_0000, 32'($urandom), 24'h00_0000, 16'h0000};
        settings[3] = '{32'sh7FFF_FFFF, -32'sd12345, 32'sh8000_0000, 24'hFF_FFFF, 16'h0001};
        settings[4] = '{$signed(32'($urandom_range(0, 32'h00C8_0000))) - 32'sh0064_0000,
                        32'($urandom),
                        $signed(32'($urandom_range(0, 32'h00C8_0000))) - 32'sh0064_0000,
                        24'($urandom_range(32'h0000_4000, 32'h0004_0000)),
                        16'($urandom)};
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        for (int i = 0; i < NUM_SETTINGS; i++) begin
            apply_config(settings[i]);
            if (i == 0) begin
                send_load(16'd0,     16'hFFFF);
                send_load(16'd1,     16'h0000);
                send_load(16'd256,   16'h8000);
                send_load(16'd257,   16'h1234);
                send_load(16'd65278, 16'h0001);
                send_load(16'd65279, 16'hFFFF);
                send_load(16'd65534, 16'h7FFF);
                send_load(16'd65535, 16'hFFFF);
                send_query(32'sh0000_0000, 32'sh0000_0000);
                send_query(32'sh0000_8000, 32'sh0000_8000);
                send_query(32'sh0000_C000, 32'sh0000_8000);
                send_query(32'sh0000_FFFF, 32'sh0000_FFFF);
                send_query(32'sh00FE_FFFF, 32'sh00FE_FFFF);
                send_query(32'sh00FF_0000, 32'sh0000_0000);
                send_query(32'sh0000_0000, 32'sh00FF_0000);
                send_query(-32'sd1, 32'sh0000_0000);
                send_query(32'sh0000_0000, -32'sd1);
                send_query(32'sh7FFF_FFFF, 32'sh8000_0000);
                send_query(32'sh8000_0000, 32'sh7FFF_FFFF);
            end
            stop_at = loads_sent + queries_sent + ITEMS_PER_SETTING;
            while (loads_sent + queries_sent < stop_at) begin
                pick = $urandom_range(0, 99);
                if (pick < 70) begin
                    send_query(pick_coord(active_cfg.origin_x), pick_coord(active_cfg.origin_z));
                end else if (pick < 85) begin
                    send_query($urandom, $urandom);
                end else begin
                    send_load(STORE_AW'($urandom), SAMPLE_W'($urandom));
                end
            end
            s_valid <= 1'b0;
            do @(posedge aclk); while (pending != 0);
            repeat (DRAIN_CYCLES) @(posedge aclk);
        end
        $display("Covered %0d sample loads and %0d height queries over %0d register settings.",
                 loads_sent, queries_sent, NUM_SETTINGS);
        $display("%0d queries landed inside the map interior; the rest were rejected.",
                 in_range_count);
        if (fail_count == 0) begin
            $display("heightmap_triangle_height_sampler_top regression: pass");
        end else begin
            $display("heightmap_triangle_height_sampler_top regression: fail");
        end
        $finish;
    end

endmodule
